// ===== rtl/core/flre_pkg.sv =====
// shared types and constants for the framebuffer line raster engine
// no dependencies

package flre_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;

  localparam int COORD_W = 10;
  localparam int DELTA_W = 10;
  localparam int ERR_W   = 12;

  typedef enum logic [2:0] {
    REQ_PIXEL  = 3'd0,
    REQ_LINE   = 3'd1,
    REQ_FILL   = 3'd2,
    REQ_INVERT = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  typedef struct packed {
    logic load;
    logic step;
    logic cnt_inc;
    logic rd_pix;
    logic rd_cnt;
    logic rd_idx;
    logic wr_pix;
    logic wr_fill;
    logic wr_inv;
    logic wr_clear;
    logic finish;
    logic read_out;
  } cmd_t;

  typedef struct packed {
    logic line_end;
    logic cnt_last;
  } stat_t;

endpackage

// ===== rtl/core/flre_datapath.sv =====
// datapath: page-organized pixel memory, bresenham stepping registers,
// sweep counter, inversion flag and result register; uses flre_pkg

module flre_datapath #(
  parameter int SCREEN_WIDTH  = flre_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = flre_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  flre_pkg::cmd_t     cmd,
  output flre_pkg::stat_t    stat,
  input  logic [2:0]         req_type,
  input  logic signed [8:0]  x_start,
  input  logic signed [8:0]  y_start,
  input  logic signed [8:0]  x_end,
  input  logic signed [8:0]  y_end,
  input  logic               colour,
  input  logic [9:0]         read_index,
  output logic [7:0]         read_data,
  output logic               invert_on
);

  localparam int STORE_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CW          = flre_pkg::COORD_W;
  localparam int DW          = flre_pkg::DELTA_W;
  localparam int EW          = flre_pkg::ERR_W;
  localparam logic signed [CW-1:0] X_LAST = CW'(SCREEN_WIDTH - 1);
  localparam logic signed [CW-1:0] Y_LAST = CW'(SCREEN_HEIGHT - 1);
  localparam logic signed [CW-1:0] X_LIM  = CW'(SCREEN_WIDTH);
  localparam logic signed [CW-1:0] Y_LIM  = CW'(SCREEN_HEIGHT);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata;

  logic signed [CW-1:0] cx, cy, fx, fy;
  logic [DW-1:0]        dx, dy;
  logic                 sx, sy;
  logic signed [EW-1:0] err;
  logic                 colour_q;
  logic                 flag;
  logic [ADDR_W-1:0]    cnt;
  logic [ADDR_W-1:0]    idx;
  logic                 rd_ok;

  logic signed [CW-1:0] ld_x0, ld_y0, ld_x1, ld_y1;
  logic signed [CW-1:0] xs_e, ys_e, xe_e, ye_e;
  logic signed [CW:0]   ddx, ddy;
  logic [DW-1:0]        ld_dx, ld_dy;
  logic signed [EW-1:0] ld_err;
  logic signed [EW-1:0] dx_s, dy_s, err_next;
  logic                 step_x, step_y;
  logic                 on_screen;
  logic [15:0]          pix_full;
  logic [ADDR_W-1:0]    pix_addr, raddr, waddr;
  logic [7:0]           mask, wdata;
  logic                 we;

  function automatic logic signed [CW-1:0] clamp_hi(input logic signed [CW-1:0] v,
                                                    input logic signed [CW-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  assign xs_e = $signed({x_start[8], x_start});
  assign ys_e = $signed({y_start[8], y_start});
  assign xe_e = $signed({x_end[8], x_end});
  assign ye_e = $signed({y_end[8], y_end});

  always_comb begin
    if (req_type == flre_pkg::REQ_LINE) begin
      ld_x0 = clamp_hi(xs_e, X_LAST);
      ld_y0 = clamp_hi(ys_e, Y_LAST);
      ld_x1 = clamp_hi(xe_e, X_LAST);
      ld_y1 = clamp_hi(ye_e, Y_LAST);
    end else begin
      ld_x0 = xs_e;
      ld_y0 = ys_e;
      ld_x1 = xs_e;
      ld_y1 = ys_e;
    end
    ddx    = (CW+1)'(ld_x1) - (CW+1)'(ld_x0);
    ddy    = (CW+1)'(ld_y1) - (CW+1)'(ld_y0);
    ld_dx  = (ddx < 0) ? DW'(-ddx) : DW'(ddx);
    ld_dy  = (ddy < 0) ? DW'(-ddy) : DW'(ddy);
    ld_err = (ld_dx > ld_dy) ? $signed({{(EW-DW+1){1'b0}}, ld_dx[DW-1:1]})
                             : -$signed({{(EW-DW+1){1'b0}}, ld_dy[DW-1:1]});
  end

  // bresenham error update
  assign dx_s     = $signed({{(EW-DW){1'b0}}, dx});
  assign dy_s     = $signed({{(EW-DW){1'b0}}, dy});
  assign step_x   = err > -dx_s;
  assign step_y   = err < dy_s;
  assign err_next = err - (step_x ? dy_s : EW'(0)) + (step_y ? dx_s : EW'(0));

  assign on_screen = (cx >= 0) && (cy >= 0) && (cx < X_LIM) && (cy < Y_LIM);
  assign pix_full  = 16'(cx[7:0]) + 16'(cy[7:3]) * 16'(SCREEN_WIDTH);
  assign pix_addr  = pix_full[ADDR_W-1:0];
  assign mask      = 8'(1) << cy[2:0];

  assign stat.line_end = (cx == fx) && (cy == fy);
  assign stat.cnt_last = (cnt == ADDR_W'(STORE_BYTES - 1));

  always_comb begin
    priority if (cmd.rd_pix) begin
      raddr = pix_addr;
    end else if (cmd.rd_idx) begin
      raddr = idx;
    end else begin
      raddr = cnt;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = 8'h00;
    priority if (cmd.wr_pix) begin
      we    = on_screen;
      waddr = pix_addr;
      wdata = (colour_q ^ flag) ? (rdata | mask) : (rdata & ~mask);
    end else if (cmd.wr_inv) begin
      we    = 1'b1;
      wdata = ~rdata;
    end else if (cmd.wr_fill) begin
      we    = 1'b1;
      wdata = colour_q ? 8'hFF : 8'h00;
    end else if (cmd.wr_clear) begin
      we    = 1'b1;
      wdata = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
      cnt  <= '0;
    end else begin
      if (cmd.load) begin
        cnt <= '0;
        if (req_type == flre_pkg::REQ_INVERT) begin
          flag <= ~flag;
        end
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx       <= ld_x0;
      cy       <= ld_y0;
      fx       <= ld_x1;
      fy       <= ld_y1;
      dx       <= ld_dx;
      dy       <= ld_dy;
      sx       <= ld_x0 < ld_x1;
      sy       <= ld_y0 < ld_y1;
      err      <= ld_err;
      colour_q <= colour;
      idx      <= ADDR_W'(read_index);
      rd_ok    <= {6'b0, read_index} < 16'(STORE_BYTES);
    end else if (cmd.step) begin
      err <= err_next;
      if (step_x) begin
        cx <= sx ? cx + CW'(1) : cx - CW'(1);
      end
      if (step_y) begin
        cy <= sy ? cy + CW'(1) : cy - CW'(1);
      end
    end
    if (cmd.finish) begin
      read_data <= (cmd.read_out && rd_ok) ? rdata : 8'h00;
    end
  end

  assign invert_on = flag;

endmodule

// ===== rtl/core/flre_ctrl.sv =====
// controller state machine: sequences clear, plot, fill, invert and read
// commands over the datapath; uses flre_pkg

module flre_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       req_type,
  input  flre_pkg::stat_t  stat,
  output flre_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [8:0] {
    ST_CLEAR     = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_PLOT_RD   = 9'b000000100,
    ST_PLOT_WR   = 9'b000001000,
    ST_FILL      = 9'b000010000,
    ST_INV_RD    = 9'b000100000,
    ST_INV_WR    = 9'b001000000,
    ST_READ_RD   = 9'b010000000,
    ST_READ_WAIT = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.wr_clear = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (stat.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (req_type)
            flre_pkg::REQ_PIXEL,
            flre_pkg::REQ_LINE:   state_next = ST_PLOT_RD;
            flre_pkg::REQ_FILL:   state_next = ST_FILL;
            flre_pkg::REQ_INVERT: state_next = ST_INV_RD;
            flre_pkg::REQ_READ:   state_next = ST_READ_RD;
            default:              cmd.finish = 1'b1;
          endcase
        end
      end
      ST_PLOT_RD: begin
        cmd.rd_pix = 1'b1;
        state_next = ST_PLOT_WR;
      end
      ST_PLOT_WR: begin
        cmd.wr_pix = 1'b1;
        if (stat.line_end) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_PLOT_RD;
        end
      end
      ST_FILL: begin
        cmd.wr_fill = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_INV_RD: begin
        cmd.rd_cnt = 1'b1;
        state_next = ST_INV_WR;
      end
      ST_INV_WR: begin
        cmd.wr_inv = 1'b1;
        if (stat.cnt_last) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = ST_INV_RD;
        end
      end
      ST_READ_RD: begin
        cmd.rd_idx = 1'b1;
        state_next = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        cmd.finish   = 1'b1;
        cmd.read_out = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/core/framebuffer_line_raster_engine_top.sv =====
// top level of the framebuffer line raster engine
// instantiates flre_ctrl and flre_datapath; uses flre_pkg
//
// usage:
//   a command beat is taken when start is high and busy is low; req_type selects
//   set pixel, draw line, fill, toggle invert or read byte, with the coordinate,
//   colour and read_index ports as operands
//   every command returns exactly one result beat: done is high for one cycle
//   with read_data (addressed byte for read byte, zero otherwise) and invert_on
//   the receiver cannot stall; done comes whether or not it is watched
// sequencing after the accept edge:
//   set pixel and draw line read then write each plotted point, the points
//   being one per step of the longer axis; fill writes every byte in turn;
//   toggle invert reads then writes each byte; read byte reads then waits; unused codes finish on acceptance
//   every pixel is a read-modify-write through the single memory port pair
// busy is low in the done cycle, so the next command may follow at once
// reset: synchronous; afterwards a clearing pass zeroes the memory one byte per
//   cycle, all STORE_BYTES bytes (1024 at the default 128 x 64), busy stays high

module framebuffer_line_raster_engine_top #(
  parameter int SCREEN_WIDTH  = flre_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = flre_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        req_type,
  input  logic signed [8:0] x_start,
  input  logic signed [8:0] y_start,
  input  logic signed [8:0] x_end,
  input  logic signed [8:0] y_end,
  input  logic              colour,
  input  logic [9:0]        read_index,
  output logic              done,
  output logic [7:0]        read_data,
  output logic              invert_on
);

  flre_pkg::cmd_t  cmd;
  flre_pkg::stat_t stat;

  flre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  flre_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .colour     (colour),
    .read_index (read_index),
    .read_data  (read_data),
    .invert_on  (invert_on)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while engine busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither running nor finished");

  a_flag_hold: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy && req_type == flre_pkg::REQ_INVERT) |=> $stable(invert_on))
    else $error("invert flag changed without an invert command");

  a_one_write_src: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wr_pix, cmd.wr_inv, cmd.wr_fill, cmd.wr_clear}))
    else $error("more than one memory write source");

endmodule

// ===== test/tb.sv =====
// testbench for framebuffer_line_raster_engine_top: directed and random commands
// checked beat by beat against a scoreboard that models the page-organized store
// depends on flre_pkg and the framebuffer line raster engine rtl
`timescale 1ns / 1ps

module tb;

  localparam int FB_W     = flre_pkg::SCREEN_WIDTH_DEF;
  localparam int FB_H     = flre_pkg::SCREEN_HEIGHT_DEF;
  localparam int FB_BYTES = FB_W * ((FB_H + 7) / 8);
  localparam int IDLE_PCT = 23;
  localparam int TAIL_CYC = 2 * FB_BYTES + 100;

  typedef struct {
    logic [2:0]        req;
    logic signed [8:0] xs;
    logic signed [8:0] ys;
    logic signed [8:0] xe;
    logic signed [8:0] ye;
    logic              colour;
    logic [9:0]        idx;
  } raster_cmd_t;

  typedef struct {
    logic [7:0] read_data;
    logic       invert_on;
  } readout_t;

  class raster_scoreboard;
    logic [7:0] pix_mem [FB_BYTES];
    logic       inv_flag;
    readout_t   due_q [$];
    int         mismatches;
    int         kind_seen [8];

    function new();
      foreach (pix_mem[i]) pix_mem[i] = 8'h00;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      inv_flag   = 1'b0;
      mismatches = 0;
    endfunction

    function void plot(int x, int y, logic col);
      int addr;
      logic [7:0] m;
      if (x < 0 || y < 0 || x >= FB_W || y >= FB_H) return;
      addr = x + (y / 8) * FB_W;
      m = 8'd1 << (y % 8);
      if (col ^ inv_flag) pix_mem[addr] = pix_mem[addr] | m;
      else pix_mem[addr] = pix_mem[addr] & ~m;
    endfunction

    function void draw_line(int x0, int y0, int x1, int y1, logic col);
      int dx, dy, sx, sy, err, e2, lo, hi;
      if (x0 >= FB_W) x0 = FB_W - 1;
      if (x1 >= FB_W) x1 = FB_W - 1;
      if (y0 >= FB_H) y0 = FB_H - 1;
      if (y1 >= FB_H) y1 = FB_H - 1;
      dx = (x0 < x1) ? x1 - x0 : x0 - x1;
      dy = (y0 < y1) ? y1 - y0 : y0 - y1;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = (dx > dy) ? dx / 2 : -(dy / 2);
      if (dx == 0) begin
        lo = (y0 < y1) ? y0 : y1;
        hi = (y0 < y1) ? y1 : y0;
        for (int i = lo; i <= hi; i++) plot(x0, i, col);
        return;
      end
      if (dy == 0) begin
        lo = (x0 < x1) ? x0 : x1;
        hi = (x0 < x1) ? x1 : x0;
        for (int i = lo; i <= hi; i++) plot(i, y0, col);
        return;
      end
      forever begin
        plot(x0, y0, col);
        if (x0 == x1 && y0 == y1) break;
        e2 = err;
        if (e2 > -dx) begin
          err -= dy;
          x0 += sx;
        end
        if (e2 < dy) begin
          err += dx;
          y0 += sy;
        end
      end
    endfunction

    function void note_command(raster_cmd_t c);
      readout_t r;
      int xs, ys, xe, ye;
      xs = $signed(c.xs);
      ys = $signed(c.ys);
      xe = $signed(c.xe);
      ye = $signed(c.ye);
      r.read_data = 8'h00;
      kind_seen[c.req]++;
      unique case (c.req)
        flre_pkg::REQ_PIXEL:  plot(xs, ys, c.colour);
        flre_pkg::REQ_LINE:   draw_line(xs, ys, xe, ye, c.colour);
        flre_pkg::REQ_FILL:   foreach (pix_mem[i]) pix_mem[i] = c.colour ? 8'hFF : 8'h00;
        flre_pkg::REQ_INVERT: begin
          inv_flag = ~inv_flag;
          foreach (pix_mem[i]) pix_mem[i] = ~pix_mem[i];
        end
        flre_pkg::REQ_READ:   if (c.idx < FB_BYTES) r.read_data = pix_mem[c.idx];
        default: ;
      endcase
      r.invert_on = inv_flag;
      due_q.push_back(r);
    endfunction

    function void flag(string what, logic [7:0] exp_v, logic [7:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
    endfunction

    function void check_readout(logic [7:0] rd, logic inv);
      readout_t e;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t result beat with nothing pending: read_data %h invert_on %b",
                   $realtime, rd, inv);
        return;
      end
      e = due_q.pop_front();
      if (rd !== e.read_data) flag("read_data", e.read_data, rd);
      if (inv !== e.invert_on) flag("invert_on", 8'(e.invert_on), 8'(inv));
    endfunction
  endclass

  logic              clk;
  logic              rst        = 1'b1;
  logic              start      = 1'b0;
  logic              busy;
  logic [2:0]        req_type   = 3'd0;
  logic signed [8:0] x_start    = 9'sd0;
  logic signed [8:0] y_start    = 9'sd0;
  logic signed [8:0] x_end      = 9'sd0;
  logic signed [8:0] y_end      = 9'sd0;
  logic              colour     = 1'b0;
  logic [9:0]        read_index = 10'd0;
  logic              done;
  logic [7:0]        read_data;
  logic              invert_on;

  raster_scoreboard sb = new();
  int idle_pct = IDLE_PCT;

  framebuffer_line_raster_engine_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .colour     (colour),
    .read_index (read_index),
    .done       (done),
    .read_data  (read_data),
    .invert_on  (invert_on)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #150_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result beat is checked before the command taken on the same edge is noted
  always @(posedge clk) begin
    raster_cmd_t c;
    if (!rst) begin
      if (done === 1'b1) sb.check_readout(read_data, invert_on);
      if (start === 1'b1 && busy === 1'b0) begin
        c.req    = req_type;
        c.xs     = x_start;
        c.ys     = y_start;
        c.xe     = x_end;
        c.ye     = y_end;
        c.colour = colour;
        c.idx    = read_index;
        sb.note_command(c);
      end
    end
  end

  function automatic raster_cmd_t mk_cmd(logic [2:0] req, int xs, int ys, int xe, int ye,
                                         logic col, int idx);
    raster_cmd_t c;
    c.req    = req;
    c.xs     = 9'(xs);
    c.ys     = 9'(ys);
    c.xe     = 9'(xe);
    c.ye     = 9'(ye);
    c.colour = col;
    c.idx    = 10'(idx);
    return c;
  endfunction

  function automatic logic signed [8:0] pick_coord(int span);
    if ($urandom_range(99) < 20) return 9'($urandom);
    return 9'($urandom_range(span - 1, 0));
  endfunction

  function automatic raster_cmd_t random_cmd();
    raster_cmd_t c;
    int r;
    r        = $urandom_range(99);
    c.xs     = pick_coord(FB_W);
    c.ys     = pick_coord(FB_H);
    c.xe     = pick_coord(FB_W);
    c.ye     = pick_coord(FB_H);
    c.colour = 1'($urandom_range(1));
    c.idx    = 10'($urandom);
    if (r < 30) c.req = flre_pkg::REQ_READ;
    else if (r < 55) c.req = flre_pkg::REQ_PIXEL;
    else if (r < 85) c.req = flre_pkg::REQ_LINE;
    else if (r < 90) c.req = flre_pkg::REQ_FILL;
    else if (r < 95) c.req = flre_pkg::REQ_INVERT;
    else c.req = 3'(flre_pkg::REQ_READ) + 3'($urandom_range(3, 1));
    return c;
  endfunction

  // returns on the edge at which the beat is taken
  task automatic send_cmd(raster_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= c.req;
    x_start    <= c.xs;
    y_start    <= c.ys;
    x_end      <= c.xe;
    y_end      <= c.ye;
    colour     <= c.colour;
    read_index <= c.idx;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.due_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    raster_cmd_t directed [$];
    int leftover;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(mk_cmd(flre_pkg::REQ_READ, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_PIXEL, 0, 0, 0, 0, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_PIXEL, 127, 63, 0, 0, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_PIXEL, -1, 5, 0, 0, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_PIXEL, 128, 10, 0, 0, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_PIXEL, 5, -256, 0, 0, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_PIXEL, 255, 255, 0, 0, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_READ, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_READ, 0, 0, 0, 0, 0, 1023));
    directed.push_back(mk_cmd(flre_pkg::REQ_LINE, 10, 10, 10, 10, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_LINE, 20, -5, 20, 70, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_LINE, -10, 30, 255, 30, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_LINE, 0, 0, 63, 63, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_LINE, 100, -256, 110, 255, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_LINE, 127, 0, -256, 40, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_INVERT, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_PIXEL, 10, 10, 0, 0, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_READ, 0, 0, 0, 0, 0, FB_W + 10));
    directed.push_back(mk_cmd(flre_pkg::REQ_LINE, 0, 63, 127, 0, 0, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_INVERT, 0, 0, 0, 0, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_FILL, 0, 0, 0, 0, 1, 0));
    directed.push_back(mk_cmd(flre_pkg::REQ_READ, 0, 0, 0, 0, 0, 512));
    directed.push_back(mk_cmd(flre_pkg::REQ_FILL, 0, 0, 0, 0, 0, 0));
    for (int k = 1; k <= 3; k++)
      directed.push_back(mk_cmd(3'(flre_pkg::REQ_READ) + 3'(k), -1, -1, -1, -1, 1, 1023));

    foreach (directed[i]) send_cmd(directed[i]);

    for (int n = 0; n < 900; n++) begin
      idle_pct = (n >= 300 && n < 450) ? 0 : IDLE_PCT;
      if (n == 500) drain_results();
      send_cmd(random_cmd());
    end

    start <= 1'b0;
    while (sb.due_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    leftover = sb.due_q.size();
    $display("covered %0d pixel, %0d line, %0d fill, %0d invert and %0d read commands,",
             sb.kind_seen[flre_pkg::REQ_PIXEL], sb.kind_seen[flre_pkg::REQ_LINE],
             sb.kind_seen[flre_pkg::REQ_FILL], sb.kind_seen[flre_pkg::REQ_INVERT],
             sb.kind_seen[flre_pkg::REQ_READ]);
    $display("plus %0d spare-code commands; %0d mismatches",
             sb.kind_seen[5] + sb.kind_seen[6] + sb.kind_seen[7], sb.mismatches);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
